// ===== rtl/lfu_pkg.sv =====
package lfu_pkg;

    // Cache geometry
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Field widths
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int USES_W  = 32;
    localparam int STAMP_W = 32;
    localparam int CAP_W   = 5;

    localparam int DEFAULT_CAPACITY = 10;

    // Operation codes
    localparam logic KIND_SET = 1'b0;
    localparam logic KIND_GET = 1'b1;

    // One stored entry; valid flags live in flops outside the RAM
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [USES_W-1:0]  uses;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    // Usable entries for a capacity setting: zero picks the default,
    // anything beyond the store saturates to its size
    function automatic logic [CNT_W-1:0] usable_slots(input logic [CAP_W-1:0] cap);
        int c;
        c = (cap == '0) ? DEFAULT_CAPACITY : int'(cap);
        if (c > MAX_ENTRIES) begin
            c = MAX_ENTRIES;
        end
        return CNT_W'(c);
    endfunction

endpackage

// ===== rtl/lfu_ram.sv =====
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/lfu_cache_policy.sv =====
// Least-frequently-used key/value cache with up to 16 entries. Each item is a
// set (kind 0) or a get (kind 1) on a key and returns exactly one result: hit
// tells whether the key was present, read_value carries the stored value on a
// get hit and zero otherwise. A set miss on a full cache evicts the entry with
// the lowest use count, the oldest one among equal counts, then inserts with
// count 1. Entries live in a single-port-read RAM and are scanned one per
// cycle: the item is accepted, every entry is read, the last read returns,
// and the write-back posts the result once the output register is free.
// The finished result sits in an output register, so the next item is
// accepted while it waits. Valid flags are flops cleared by reset; there is
// no clearing pass. The capacity register (cfg_data) is written only while
// the block is idle; zero selects ten entries.
module lfu_cache_policy (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]      cfg_data,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic [lfu_pkg::KEY_W-1:0]      s_key,
    input  logic [lfu_pkg::VAL_W-1:0]      s_write_value,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_hit,
    output logic [lfu_pkg::VAL_W-1:0]      m_read_value
);

    localparam int MAX   = lfu_pkg::MAX_ENTRIES;
    localparam int IDX_W = lfu_pkg::IDX_W;
    localparam int CNT_W = lfu_pkg::CNT_W;

    lfu_pkg::state_t state_reg, state_next;

    logic [lfu_pkg::CAP_W-1:0]   cap_reg;
    logic [MAX-1:0]              valid_reg;
    logic [CNT_W-1:0]            occ_reg;
    logic [lfu_pkg::STAMP_W-1:0] stamp_cnt_reg;

    // Latched item
    logic                        kind_reg;
    logic [lfu_pkg::KEY_W-1:0]   key_reg;
    logic [lfu_pkg::VAL_W-1:0]   wval_reg;

    // Scan control
    logic [CNT_W-1:0]            scan_cnt_reg;
    logic                        cmp_vld_reg;
    logic [IDX_W-1:0]            cmp_idx_reg;

    // Scan results
    logic                        hit_reg;
    logic [IDX_W-1:0]            hit_idx_reg;
    logic [lfu_pkg::VAL_W-1:0]   hit_value_reg;
    logic [lfu_pkg::USES_W-1:0]  hit_uses_reg;
    logic                        vic_found_reg;
    logic [IDX_W-1:0]            vic_idx_reg;
    logic [lfu_pkg::USES_W-1:0]  vic_uses_reg;
    logic [lfu_pkg::STAMP_W-1:0] vic_age_reg;
    logic                        free_found_reg;
    logic [IDX_W-1:0]            free_idx_reg;

    // Output register
    logic                        m_valid_reg;
    logic                        m_hit_reg;
    logic [lfu_pkg::VAL_W-1:0]   m_rval_reg;

    // RAM ports
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    lfu_pkg::entry_t             rd_entry;
    logic [lfu_pkg::ENTRY_W-1:0] rd_data;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    lfu_pkg::entry_t             wr_entry;

    logic                        in_fire;
    logic                        out_free;
    logic                        commit;
    logic                        cur_valid;
    logic [lfu_pkg::STAMP_W-1:0] cur_age;
    logic                        take_victim;
    logic                        need_evict;
    logic                        do_evict;
    logic                        do_insert;
    logic [IDX_W-1:0]            ins_idx;
    logic [lfu_pkg::USES_W-1:0]  hit_uses_inc;

    assign cfg_ready    = (state_reg == lfu_pkg::ST_IDLE);
    assign s_ready      = (state_reg == lfu_pkg::ST_IDLE);
    assign in_fire      = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_read_value = m_rval_reg;
    assign out_free     = !m_valid_reg || m_ready;
    assign commit       = (state_reg == lfu_pkg::ST_WRITE) && out_free;

    lfu_ram #(
        .WIDTH (lfu_pkg::ENTRY_W),
        .DEPTH (MAX)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_entry = lfu_pkg::entry_t'(rd_data);

    // Issue one read per cycle during the scan
    assign rd_en   = (state_reg == lfu_pkg::ST_SCAN) && (scan_cnt_reg != CNT_W'(MAX));
    assign rd_addr = scan_cnt_reg[IDX_W-1:0];

    // Compare the entry returned this cycle
    assign cur_valid   = valid_reg[cmp_idx_reg];
    assign cur_age     = stamp_cnt_reg - rd_entry.stamp;
    assign take_victim = !vic_found_reg || (rd_entry.uses < vic_uses_reg) ||
                         ((rd_entry.uses == vic_uses_reg) && (cur_age > vic_age_reg));

    // Decide the write-back
    assign hit_uses_inc = (hit_uses_reg == '1) ? hit_uses_reg : hit_uses_reg + 1'b1;
    assign need_evict   = (occ_reg >= lfu_pkg::usable_slots(cap_reg));
    assign do_evict     = !hit_reg && (kind_reg == lfu_pkg::KIND_SET) && need_evict &&
                          vic_found_reg;
    assign ins_idx      = (do_evict && (!free_found_reg || (vic_idx_reg < free_idx_reg))) ?
                          vic_idx_reg : free_idx_reg;
    assign do_insert    = !hit_reg && (kind_reg == lfu_pkg::KIND_SET) &&
                          (free_found_reg || do_evict);

    always_comb begin
        wr_en          = 1'b0;
        wr_addr        = ins_idx;
        wr_entry.key   = key_reg;
        wr_entry.value = wval_reg;
        wr_entry.uses  = lfu_pkg::USES_W'(1);
        wr_entry.stamp = stamp_cnt_reg;
        if (commit) begin
            if (hit_reg) begin
                wr_en         = 1'b1;
                wr_addr       = hit_idx_reg;
                wr_entry.uses = hit_uses_inc;
                if (kind_reg == lfu_pkg::KIND_GET) begin
                    wr_entry.value = hit_value_reg;
                end
            end else begin
                wr_en = do_insert;
            end
        end
    end

    // Sequence one item at a time
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lfu_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN: begin
                if ((scan_cnt_reg == CNT_W'(MAX)) && cmp_vld_reg) begin
                    state_next = lfu_pkg::ST_WRITE;
                end
            end
            lfu_pkg::ST_WRITE: begin
                if (out_free) begin
                    state_next = lfu_pkg::ST_IDLE;
                end
            end
            default: state_next = lfu_pkg::ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lfu_pkg::ST_IDLE;
            cap_reg       <= lfu_pkg::CAP_W'(lfu_pkg::DEFAULT_CAPACITY);
            valid_reg     <= '0;
            occ_reg       <= '0;
            stamp_cnt_reg <= '0;
            scan_cnt_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= rd_en;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            if (in_fire) begin
                scan_cnt_reg <= '0;
            end else if (rd_en) begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            // Drop the victim, then mark the inserted slot
            if (commit) begin
                if (hit_reg) begin
                    stamp_cnt_reg <= stamp_cnt_reg + 1'b1;
                end else if (do_insert) begin
                    stamp_cnt_reg <= stamp_cnt_reg + 1'b1;
                    if (!do_evict) begin
                        occ_reg <= occ_reg + 1'b1;
                    end
                end else if (do_evict) begin
                    occ_reg <= occ_reg - 1'b1;
                end
                if (do_evict || do_insert) begin
                    valid_reg <= (valid_reg & ~(MAX'(do_evict) << vic_idx_reg)) |
                                 (MAX'(do_insert) << ins_idx);
                end
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and scan trackers
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= rd_addr;
        if (in_fire) begin
            kind_reg       <= s_kind;
            key_reg        <= s_key;
            wval_reg       <= s_write_value;
            hit_reg        <= 1'b0;
            vic_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmp_vld_reg) begin
            if (cur_valid && (rd_entry.key == key_reg) && !hit_reg) begin
                hit_reg       <= 1'b1;
                hit_idx_reg   <= cmp_idx_reg;
                hit_value_reg <= rd_entry.value;
                hit_uses_reg  <= rd_entry.uses;
            end
            if (cur_valid && take_victim) begin
                vic_found_reg <= 1'b1;
                vic_idx_reg   <= cmp_idx_reg;
                vic_uses_reg  <= rd_entry.uses;
                vic_age_reg   <= cur_age;
            end
            if (!cur_valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= cmp_idx_reg;
            end
        end
        if (commit) begin
            m_hit_reg  <= hit_reg;
            m_rval_reg <= (hit_reg && (kind_reg == lfu_pkg::KIND_GET)) ? hit_value_reg : '0;
        end
    end

endmodule

// ===== rtl/lfu_checker.sv =====
module lfu_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_hit,
    input logic [lfu_pkg::VAL_W-1:0]   m_read_value
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_read_value))
        else $error("result changed while stalled");

    // A miss never returns data
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_read_value == '0)
        else $error("miss returned nonzero data");

    // One item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken during scan");

    // Reset empties the output
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind lfu_cache_policy lfu_checker u_lfu_checker (.*);

// ===== tb/tb_lfu_cache_policy.sv =====
`timescale 1ns / 1ps

// One expected response of the cache
typedef struct packed {
    logic                      hit;
    logic [lfu_pkg::VAL_W-1:0] read_value;
} lookup_result_t;

// Shadow copy of the LFU store: predicts each response and checks it in order
class lfu_shadow_cache;
    lfu_pkg::entry_t             slot [lfu_pkg::MAX_ENTRIES];
    bit                          slot_live [lfu_pkg::MAX_ENTRIES];
    int unsigned                 occupied;
    logic [lfu_pkg::STAMP_W-1:0] stamp_now;
    logic [lfu_pkg::CAP_W-1:0]   capacity;
    lookup_result_t              pending_lookups [$];
    int                          failures;

    function new();
        foreach (slot_live[i]) slot_live[i] = 1'b0;
        occupied  = 0;
        stamp_now = '0;
        capacity  = lfu_pkg::CAP_W'(lfu_pkg::DEFAULT_CAPACITY);
        failures  = 0;
    endfunction

    function void set_capacity(logic [lfu_pkg::CAP_W-1:0] cap);
        capacity = cap;
    endfunction

    function int pending();
        return pending_lookups.size();
    endfunction

    // Zero means the default; anything beyond the store saturates
    function int unsigned usable();
        int unsigned c;
        c = capacity;
        if (c == 0) c = lfu_pkg::DEFAULT_CAPACITY;
        if (c > lfu_pkg::MAX_ENTRIES) c = lfu_pkg::MAX_ENTRIES;
        return c;
    endfunction

    // Drop the entry with the lowest count, oldest first among equal counts
    function void evict_lfu();
        int                          victim;
        logic [lfu_pkg::USES_W-1:0]  best_uses;
        logic [lfu_pkg::STAMP_W-1:0] best_age;
        logic [lfu_pkg::STAMP_W-1:0] age;
        victim    = -1;
        best_uses = '0;
        best_age  = '0;
        for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
            if (!slot_live[i]) continue;
            age = stamp_now - slot[i].stamp;
            if (victim < 0 || slot[i].uses < best_uses ||
                (slot[i].uses == best_uses && age > best_age)) begin
                victim    = i;
                best_uses = slot[i].uses;
                best_age  = age;
            end
        end
        if (victim >= 0) begin
            slot_live[victim] = 1'b0;
            if (occupied > 0) occupied--;
        end
    endfunction

    // Apply one accepted request and queue the response it must produce
    function void note_request(logic kind, logic [lfu_pkg::KEY_W-1:0] key,
                               logic [lfu_pkg::VAL_W-1:0] wval);
        int             found;
        lookup_result_t res;
        found = -1;
        res   = '0;
        for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
            if (slot_live[i] && slot[i].key == key) begin
                found = i;
                break;
            end
        end
        if (found >= 0) begin
            res.hit = 1'b1;
            if (kind == lfu_pkg::KIND_GET) begin
                res.read_value = slot[found].value;
            end else begin
                slot[found].value = wval;
            end
            // Hold a saturated count, but always refresh the stamp
            if (slot[found].uses != '1) slot[found].uses = slot[found].uses + 1'b1;
            slot[found].stamp = stamp_now;
            stamp_now = stamp_now + 1'b1;
        end else if (kind == lfu_pkg::KIND_SET) begin
            if (occupied >= usable()) evict_lfu();
            for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
                if (!slot_live[i]) begin
                    slot_live[i]   = 1'b1;
                    slot[i].key    = key;
                    slot[i].value  = wval;
                    slot[i].uses   = 1;
                    slot[i].stamp  = stamp_now;
                    stamp_now      = stamp_now + 1'b1;
                    occupied++;
                    break;
                end
            end
        end
        pending_lookups = {pending_lookups, res};
    endfunction

    // Compare one response against the oldest prediction
    function void check_response(logic hit, logic [lfu_pkg::VAL_W-1:0] read_value);
        lookup_result_t want;
        if (pending_lookups.size() == 0) begin
            $display("%0t: response with none outstanding, hit=%0b read_value=%h",
                     $time, hit, read_value);
            failures++;
            return;
        end
        want = pending_lookups.pop_front();
        if (want.hit !== hit) begin
            $display("%0t: hit mismatch, expected %0b actual %0b", $time, want.hit, hit);
            failures++;
        end
        if (want.read_value !== read_value) begin
            $display("%0t: read_value mismatch, expected %h actual %h",
                     $time, want.read_value, read_value);
            failures++;
        end
    endfunction
endclass

module tb_lfu_cache_policy;

    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE_WAIT  = 25;
    localparam int PHASE_ITEMS  = 175;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [lfu_pkg::CAP_W-1:0]   cfg_data;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_kind;
    logic [lfu_pkg::KEY_W-1:0]   s_key;
    logic [lfu_pkg::VAL_W-1:0]   s_write_value;
    logic                        m_valid;
    logic                        m_ready;
    logic                        m_hit;
    logic [lfu_pkg::VAL_W-1:0]   m_read_value;

    lfu_shadow_cache             shadow = new();
    logic [lfu_pkg::KEY_W-1:0]   key_pool [$];
    bit                          quiet;
    int                          idle_cycles = 0;

    lfu_cache_policy uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_key         (s_key),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_read_value  (m_read_value)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    // Offer one item and hold it until accepted; valid stays up afterwards
    task automatic send_item(logic kind, logic [lfu_pkg::KEY_W-1:0] key,
                             logic [lfu_pkg::VAL_W-1:0] wval);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_key         <= key;
        s_write_value <= wval;
        do @(posedge aclk); while (!s_ready);
        shadow.note_request(kind, key, wval);
    endtask

    // Hold the sender until every outstanding response has come back
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [lfu_pkg::CAP_W-1:0] cap);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow.set_capacity(cap);
    endtask

    // Skewed pick from the pool so some keys gather far higher counts
    function automatic logic [lfu_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return key_pool[$urandom_range(0, $urandom_range(0, key_pool.size() - 1))];
    endfunction

    // Result sink with random back-pressure
    initial begin
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Check responses and watch for a stalled handshake
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            shadow.check_response(m_hit, m_read_value);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int cap_plan [10];
        cap_plan      = '{16, 1, 0, 31, 3, 17, 2, 10, 8, 0};
        cap_plan[9]   = $urandom_range(0, 31);
        quiet         = 1'b0;
        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_kind        <= lfu_pkg::KIND_SET;
        s_key         <= '0;
        s_write_value <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset capacity of ten, key and value extremes, fill and evict
        send_item(lfu_pkg::KIND_GET, 32'h0, 32'h0);
        send_item(lfu_pkg::KIND_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(lfu_pkg::KIND_SET, 32'h0, 32'hFFFF_FFFF);
        send_item(lfu_pkg::KIND_SET, 32'hFFFF_FFFF, 32'h0);
        send_item(lfu_pkg::KIND_GET, 32'h0, 32'h0);
        send_item(lfu_pkg::KIND_GET, 32'hFFFF_FFFF, 32'h0);
        send_item(lfu_pkg::KIND_SET, 32'h0, 32'h1234_5678);
        send_item(lfu_pkg::KIND_GET, 32'h0, 32'hFFFF_FFFF);
        for (int k = 1; k <= 8; k++) send_item(lfu_pkg::KIND_SET, k, $urandom);
        send_item(lfu_pkg::KIND_GET, 32'h1, 32'h0);
        send_item(lfu_pkg::KIND_GET, 32'h1, 32'h0);
        send_item(lfu_pkg::KIND_GET, 32'h2, 32'h0);
        send_item(lfu_pkg::KIND_SET, 32'h100, $urandom);
        send_item(lfu_pkg::KIND_GET, 32'hFFFF_FFFF, 32'h0);
        send_item(lfu_pkg::KIND_SET, 32'h200, $urandom);
        send_item(lfu_pkg::KIND_GET, 32'h3, 32'h0);

        // Random phases; the drop from sixteen to one runs with a full store
        foreach (cap_plan[p]) begin
            write_capacity(lfu_pkg::CAP_W'(cap_plan[p]));
            key_pool.delete();
            repeat ($urandom_range(4, 22)) begin
                key_pool = {key_pool, lfu_pkg::KEY_W'($urandom)};
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 149) == 0) wait_until_drained();
                send_item($urandom_range(0, 1) ? lfu_pkg::KIND_GET : lfu_pkg::KIND_SET,
                          pick_key(), $urandom);
            end
        end

        wait_until_drained();
        if (shadow.failures == 0 && shadow.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
